/* src/fkc_pkg.sv */
// ----------------------------------------------------------------------------
// fkc_pkg: shared definitions for the keypad calculator
// Key codes, pending operator codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package fkc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OUT_W          = 32;
  localparam int PEND_W         = 3;

  // Key kinds
  localparam logic [1:0] CMD_DIGIT  = 2'd0;
  localparam logic [1:0] CMD_OPER   = 2'd1;
  localparam logic [1:0] CMD_EQUALS = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Operator key codes
  localparam logic [1:0] KEY_ADD = 2'd0;
  localparam logic [1:0] KEY_SUB = 2'd1;
  localparam logic [1:0] KEY_MUL = 2'd2;
  localparam logic [1:0] KEY_DIV = 2'd3;

  // Pending operator codes
  localparam logic [PEND_W-1:0] OP_NONE = 3'd0;
  localparam logic [PEND_W-1:0] OP_ADD  = 3'd1;
  localparam logic [PEND_W-1:0] OP_SUB  = 3'd2;
  localparam logic [PEND_W-1:0] OP_MUL  = 3'd3;
  localparam logic [PEND_W-1:0] OP_DIV  = 3'd4;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic load_key;
    logic start;
    logic step;
    logic commit;
  } fkc_cmd_t;

  typedef struct packed {
    logic [1:0]        key_cmd;
    logic [PEND_W-1:0] pend;
    logic              last_step;
  } fkc_sts_t;

  function automatic logic [PEND_W-1:0] op_from_key(input logic [1:0] code);
    logic [PEND_W-1:0] op;
    case (code)
      KEY_ADD: op = OP_ADD;
      KEY_SUB: op = OP_SUB;
      KEY_MUL: op = OP_MUL;
      default: op = OP_DIV;
    endcase
    return op;
  endfunction

endpackage

/* src/fkc_if.sv */
// ----------------------------------------------------------------------------
// fkc_if: key and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fkc_key_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] digit;
  logic [1:0] operator_code;

  modport source (output valid, cmd, digit, operator_code, input ready);
  modport sink   (input valid, cmd, digit, operator_code, output ready);
endinterface

interface fkc_res_if;
  logic                            valid;
  logic                            ready;
  logic signed [fkc_pkg::OUT_W-1:0] value;
  logic                            computed;
  logic                            div_by_zero;
  logic                            operator_pending;

  modport source (output valid, value, computed, div_by_zero, operator_pending,
                  input ready);
  modport sink   (input valid, value, computed, div_by_zero, operator_pending,
                  output ready);
endinterface

/* src/four_function_keypad_calculator_top.sv */
// Flow: an accepted key passes through DECODE, then WRITE, where its result is
// registered once the result channel is free; a key that evaluates a pending
// multiply or divide passes through RUN between them (one bit per cycle through the
// shared shift-add / restoring unit). A new key is taken only after write-back.
// A key is taken while the previous result beat still waits at the output.
// Reset (synchronous, active high) clears operands, pending operator and result.
// ----------------------------------------------------------------------------
// four_function_keypad_calculator_top: keypad calculator core
// Joins the key sequencer and the datapath to the key and result channels.
// ----------------------------------------------------------------------------
module four_function_keypad_calculator_top #(
  parameter int DATA_WIDTH = fkc_pkg::DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  fkc_key_if.sink  key,
  fkc_res_if.source res
);

  fkc_pkg::fkc_cmd_t cmd;
  fkc_pkg::fkc_sts_t sts;

  fkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (key.valid),
    .in_ready  (key.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fkc_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .key_cmd          (key.cmd),
    .key_digit        (key.digit),
    .key_op           (key.operator_code),
    .value            (res.value),
    .computed         (res.computed),
    .div_by_zero      (res.div_by_zero),
    .operator_pending (res.operator_pending)
  );

endmodule

/* src/fkc_ctrl.sv */
// ----------------------------------------------------------------------------
// fkc_ctrl: key sequencer
// Steps each key through decode, optional multiply/divide iterations and
// write-back, and owns the key ready and result valid handshakes.
// ----------------------------------------------------------------------------
module fkc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fkc_pkg::fkc_sts_t sts,
  output fkc_pkg::fkc_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DECODE,
    RUN,
    WRITE
  } state_t;

  state_t state;
  logic   iterate;
  logic   commit;

  assign iterate = (sts.key_cmd inside {fkc_pkg::CMD_OPER, fkc_pkg::CMD_EQUALS})
                && (sts.pend inside {fkc_pkg::OP_MUL, fkc_pkg::OP_DIV});
  assign commit  = (state == WRITE) && (!out_valid || out_ready);

  always_comb begin
    cmd.load_key = (state == IDLE) && in_valid && in_ready;
    cmd.start    = (state == DECODE) && iterate;
    cmd.step     = (state == RUN);
    cmd.commit   = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            state    <= DECODE;
            in_ready <= 1'b0;
          end
        end
        DECODE: begin
          state <= iterate ? RUN : WRITE;
        end
        RUN: begin
          if (sts.last_step) state <= WRITE;
        end
        WRITE: begin
          if (commit) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
      // hold the result beat until taken
      if (commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* src/fkc_dp.sv */
// ----------------------------------------------------------------------------
// fkc_dp: calculator datapath
// Operand registers, digit entry, add/subtract, a shared shift-add
// multiplier / restoring divider, and the result register.
// ----------------------------------------------------------------------------
module fkc_dp #(
  parameter int DATA_WIDTH = fkc_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fkc_pkg::fkc_cmd_t                cmd,
  output fkc_pkg::fkc_sts_t                sts,
  input  logic [1:0]                       key_cmd,
  input  logic [3:0]                       key_digit,
  input  logic [1:0]                       key_op,
  output logic signed [fkc_pkg::OUT_W-1:0] value,
  output logic                             computed,
  output logic                             div_by_zero,
  output logic                             operator_pending
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic [1:0]                k_cmd;
  logic [3:0]                k_digit;
  logic [1:0]                k_op;

  logic [DATA_WIDTH-1:0]     first_op, second_op, last_result;
  logic [fkc_pkg::PEND_W-1:0] pend;

  logic [DATA_WIDTH-1:0]     acc, sreg, opnd;
  logic                      neg_q;
  logic [CW-1:0]             count;

  logic [DATA_WIDTH-1:0]     first_next, second_next, last_next;
  logic [fkc_pkg::PEND_W-1:0] pend_next;
  logic                      computed_next, dz_next;

  logic [DATA_WIDTH-1:0]     mag_a, mag_b, eval_res;
  logic                      eval_dz;
  logic [DATA_WIDTH:0]       shifted, trial;

  assign sts.key_cmd   = k_cmd;
  assign sts.pend      = pend;
  assign sts.last_step = (count == '0);

  assign mag_a   = first_op[DATA_WIDTH-1]  ? (~first_op + 1'b1)  : first_op;
  assign mag_b   = second_op[DATA_WIDTH-1] ? (~second_op + 1'b1) : second_op;
  assign shifted = {acc, sreg[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, opnd};

  always_comb begin
    eval_dz = 1'b0;
    case (pend)
      fkc_pkg::OP_ADD: eval_res = first_op + second_op;
      fkc_pkg::OP_SUB: eval_res = first_op - second_op;
      fkc_pkg::OP_MUL: eval_res = acc;
      fkc_pkg::OP_DIV: begin
        eval_dz  = (second_op == '0);
        eval_res = eval_dz ? '0 : (neg_q ? (~sreg + 1'b1) : sreg);
      end
      default: eval_res = last_result;
    endcase
  end

  always_comb begin
    first_next    = first_op;
    second_next   = second_op;
    last_next     = last_result;
    pend_next     = pend;
    computed_next = 1'b0;
    dz_next       = 1'b0;
    case (k_cmd)
      fkc_pkg::CMD_DIGIT: begin
        if (k_digit <= fkc_pkg::DIGIT_MAX) begin
          // x10 as x8 + x2
          if (pend == fkc_pkg::OP_NONE)
            first_next  = (first_op << 3) + (first_op << 1) + DATA_WIDTH'(k_digit);
          else
            second_next = (second_op << 3) + (second_op << 1) + DATA_WIDTH'(k_digit);
        end
      end
      fkc_pkg::CMD_OPER: begin
        if (pend != fkc_pkg::OP_NONE) begin
          last_next     = eval_res;
          dz_next       = eval_dz;
          computed_next = 1'b1;
          first_next    = eval_res;
          second_next   = '0;
        end
        pend_next = fkc_pkg::op_from_key(k_op);
      end
      fkc_pkg::CMD_EQUALS: begin
        if (pend != fkc_pkg::OP_NONE) begin
          last_next     = eval_res;
          dz_next       = eval_dz;
          computed_next = 1'b1;
        end
        first_next  = '0;
        second_next = '0;
        pend_next   = fkc_pkg::OP_NONE;
      end
      default: begin
        first_next  = '0;
        second_next = '0;
        pend_next   = fkc_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_op    <= '0;
      second_op   <= '0;
      last_result <= '0;
      pend        <= fkc_pkg::OP_NONE;
    end else if (cmd.commit) begin
      first_op    <= first_next;
      second_op   <= second_next;
      last_result <= last_next;
      pend        <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      k_cmd   <= key_cmd;
      k_digit <= key_digit;
      k_op    <= key_op;
    end
    if (cmd.start) begin
      acc   <= '0;
      count <= CW'(DATA_WIDTH - 1);
      neg_q <= first_op[DATA_WIDTH-1] ^ second_op[DATA_WIDTH-1];
      if (pend == fkc_pkg::OP_MUL) begin
        sreg <= second_op;
        opnd <= first_op;
      end else begin
        sreg <= mag_a;
        opnd <= mag_b;
      end
    end else if (cmd.step) begin
      count <= count - 1'b1;
      if (pend == fkc_pkg::OP_MUL) begin
        // shift-add: one multiplier bit a step
        if (sreg[0]) acc <= acc + opnd;
        opnd <= opnd << 1;
        sreg <= sreg >> 1;
      end else begin
        // restoring divide: one quotient bit a step
        if (!trial[DATA_WIDTH]) begin
          acc  <= trial[DATA_WIDTH-1:0];
          sreg <= {sreg[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc  <= shifted[DATA_WIDTH-1:0];
          sreg <= {sreg[DATA_WIDTH-2:0], 1'b0};
        end
      end
    end
    if (cmd.commit) begin
      value            <= fkc_pkg::OUT_W'($signed(last_next));
      computed         <= computed_next;
      div_by_zero      <= dz_next;
      operator_pending <= (pend_next != fkc_pkg::OP_NONE);
    end
  end

endmodule

/* src/fkc_chk.sv */
// ----------------------------------------------------------------------------
// fkc_chk: port-level checks for the keypad calculator
// Watches the key and result channels of the top level.
// ----------------------------------------------------------------------------
module fkc_chk (
  input logic clk,
  input logic rst,
  input logic key_valid,
  input logic key_ready,
  input logic res_valid,
  input logic res_ready,
  input logic computed,
  input logic div_by_zero
);

  // result beat holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped before it was taken");

  // one key in flight: ready drops after an accepted key
  a_one_key: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready |=> !key_ready)
    else $error("key accepted while another key is in flight");

  // divide by zero only reported by an evaluating key
  a_dz_computed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!div_by_zero || computed))
    else $error("div_by_zero without an evaluation");

  // reset leaves no result beat and accepts keys
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && key_ready)
    else $error("channels not idle after reset");

endmodule

bind four_function_keypad_calculator_top fkc_chk u_fkc_chk (
  .clk         (clk),
  .rst         (rst),
  .key_valid   (key.valid),
  .key_ready   (key.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .computed    (res.computed),
  .div_by_zero (res.div_by_zero)
);
